// ===== rtl/core/cascaded_position_velocity_loop_top_macros.svh =====
// assertion macros for the cascaded position/velocity loop
`ifndef CASCADED_POSITION_VELOCITY_LOOP_TOP_MACROS_SVH
`define CASCADED_POSITION_VELOCITY_LOOP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CPVL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpvl assertion failed");

// next-cycle implication, checked outside reset
`define CPVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpvl assertion failed");

`endif

// ===== rtl/core/cpvl_pkg.sv =====
// package: constants, register codes and fixed-point helpers for the position/velocity loop
`default_nettype none
package cpvl_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned FRAC_SH = 24;

  localparam logic [DATA_W-1:0]  POSITION_GAIN_RST      = 32'd5872026;
  localparam logic [DATA_W-1:0]  INTEGRAL_STEP_GAIN_RST = 32'd8389;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST     = 31'd3276800;
  localparam logic [DATA_W-1:0]  VELOCITY_GAIN_RST      = 32'd587203;
  localparam logic signed [DATA_W-1:0] DRIVE_UPPER_RST  = 32'sd983040;
  localparam logic signed [DATA_W-1:0] DRIVE_LOWER_RST  = -32'sd983040;

  typedef enum logic [IDX_W-1:0] {
    REG_POSITION_GAIN      = 3'd0,
    REG_INTEGRAL_STEP_GAIN = 3'd1,
    REG_INTEGRAL_LIMIT     = 3'd2,
    REG_VELOCITY_GAIN      = 3'd3,
    REG_DRIVE_UPPER_BOUND  = 3'd4,
    REG_DRIVE_LOWER_BOUND  = 3'd5
  } reg_idx_t;

  // exact add or subtract, saturated to signed 32 bits
  function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic sub);
    logic signed [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) begin
      sat_addsub = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_addsub = s[31:0];
    end
  endfunction

  // magnitude product >> 24 rounded half away from zero, sign applied, saturated
  function automatic logic signed [31:0] scale_finish(input logic [63:0] prod,
                                                      input logic neg);
    logic [63:0] rnd;
    logic [39:0] mag;
    rnd = prod + 64'h0000_0000_0080_0000;
    mag = rnd[63:FRAC_SH];
    if (mag > 40'h00_8000_0000) begin
      mag = 40'h00_8000_0000;
    end
    if (neg) begin
      scale_finish = ~mag[31:0] + 32'd1;
    end else if (mag[31]) begin
      scale_finish = 32'sh7fff_ffff;
    end else begin
      scale_finish = mag[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cascaded_position_velocity_loop_top.sv =====
// top level: cascaded PI position / P velocity controller on one shared multiplier
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | positions, velocity, clear_integral
//  out     | output    | out_valid / out_ready| velocity setpoint, drive command, flags
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index (3 bits), cfg_data (32 bits)
//
// after acceptance: PERR, MULP, MULI, INTEG, SETP, VERR, MULV, DRIVE, then back to idle;
// the single 32x32 multiplier forms the position, integral and velocity products of each item.
// reset (synchronous, rst_n low) loads the register defaults and zeroes the integral.
// in_ready is high only when idle; the last step waits while an earlier result is untaken.
// cfg_ready is always high.
`default_nettype none
`include "cascaded_position_velocity_loop_top_macros.svh"
module cascaded_position_velocity_loop_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_measured_position,
  input  wire logic signed [31:0] in_measured_velocity,
  input  wire logic signed [31:0] in_target_position,
  input  wire logic               in_clear_integral,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_velocity_setpoint,
  output logic signed [31:0]      out_drive_command,
  output logic                    out_drive_clamped,
  output logic                    out_integral_clamped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PERR  = 9'b000000010,
    S_MULP  = 9'b000000100,
    S_MULI  = 9'b000001000,
    S_INTEG = 9'b000010000,
    S_SETP  = 9'b000100000,
    S_VERR  = 9'b001000000,
    S_MULV  = 9'b010000000,
    S_DRIVE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]        pos_gain_r, int_gain_r, vel_gain_r;
  logic [30:0]        lim_r;
  logic signed [31:0] upper_r, lower_r;

  logic signed [31:0] pos_r, vel_r, tgt_r;
  logic signed [31:0] err_r, pterm_r, integ_r, setp_r;
  logic [63:0]        prod_r;
  logic               neg_r, iclamp_r;

  logic signed [31:0] out_vsp_r, out_drive_r;
  logic               out_valid_r, out_dclamp_r, out_iclamp_r;

  logic signed [31:0] add_a, add_b, add_y, fin_y, lim_pos, lim_neg, drive_y;
  logic signed [32:0] integ_sum, lim_pos_w, lim_neg_w;
  logic               add_sub, drive_hit, out_free;
  logic [31:0]        mul_a, mul_b, err_mag;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid             = out_valid_r;
  assign out_velocity_setpoint = out_vsp_r;
  assign out_drive_command     = out_drive_r;
  assign out_drive_clamped     = out_dclamp_r;
  assign out_integral_clamped  = out_iclamp_r;

  // shared saturating adder
  always_comb begin
    add_a   = tgt_r;
    add_b   = pos_r;
    add_sub = 1'b1;
    unique case (state_r)
      S_INTEG: begin
        add_a   = integ_r;
        add_b   = fin_y;
        add_sub = 1'b0;
      end
      S_SETP: begin
        add_a   = pterm_r;
        add_b   = integ_r;
        add_sub = 1'b0;
      end
      S_VERR: begin
        add_a   = setp_r;
        add_b   = vel_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = tgt_r;
        add_b   = pos_r;
        add_sub = 1'b1;
      end
    endcase
  end

  assign add_y = cpvl_pkg::sat_addsub(add_a, add_b, add_sub);
  assign fin_y = cpvl_pkg::scale_finish(prod_r, neg_r);

  // integral sum kept exact before the clamp
  assign integ_sum = {add_a[31], add_a} + {add_b[31], add_b};

  // shared multiplier, magnitude times gain
  assign err_mag = err_r[31] ? (~err_r + 32'd1) : err_r;
  assign mul_a   = err_mag;
  always_comb begin
    unique case (state_r)
      S_MULI:  mul_b = int_gain_r;
      S_MULV:  mul_b = vel_gain_r;
      default: mul_b = pos_gain_r;
    endcase
  end

  assign lim_pos   = signed'({1'b0, lim_r});
  assign lim_neg   = -lim_pos;
  assign lim_pos_w = {1'b0, lim_pos};
  assign lim_neg_w = -lim_pos_w;

  always_comb begin
    drive_y   = fin_y;
    drive_hit = 1'b0;
    if (fin_y > upper_r) begin
      drive_y   = upper_r;
      drive_hit = 1'b1;
    end else if (fin_y < lower_r) begin
      drive_y   = lower_r;
      drive_hit = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_PERR;
      S_PERR:  state_nxt = S_MULP;
      S_MULP:  state_nxt = S_MULI;
      S_MULI:  state_nxt = S_INTEG;
      S_INTEG: state_nxt = S_SETP;
      S_SETP:  state_nxt = S_VERR;
      S_VERR:  state_nxt = S_MULV;
      S_MULV:  state_nxt = S_DRIVE;
      S_DRIVE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, output valid, integral and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      pos_gain_r  <= cpvl_pkg::POSITION_GAIN_RST;
      int_gain_r  <= cpvl_pkg::INTEGRAL_STEP_GAIN_RST;
      lim_r       <= cpvl_pkg::INTEGRAL_LIMIT_RST;
      vel_gain_r  <= cpvl_pkg::VELOCITY_GAIN_RST;
      upper_r     <= cpvl_pkg::DRIVE_UPPER_RST;
      lower_r     <= cpvl_pkg::DRIVE_LOWER_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DRIVE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_valid && in_clear_integral) begin
        integ_r <= '0;
      end else if (state_r == S_INTEG) begin
        if (integ_sum > lim_pos_w) begin
          integ_r <= lim_pos;
        end else if (integ_sum < lim_neg_w) begin
          integ_r <= lim_neg;
        end else begin
          integ_r <= integ_sum[31:0];
        end
      end
      if (cfg_valid) begin
        unique case (cpvl_pkg::reg_idx_t'(cfg_index))
          cpvl_pkg::REG_POSITION_GAIN:      pos_gain_r <= cfg_data;
          cpvl_pkg::REG_INTEGRAL_STEP_GAIN: int_gain_r <= cfg_data;
          cpvl_pkg::REG_INTEGRAL_LIMIT:     lim_r      <= cfg_data[30:0];
          cpvl_pkg::REG_VELOCITY_GAIN:      vel_gain_r <= cfg_data;
          cpvl_pkg::REG_DRIVE_UPPER_BOUND:  upper_r    <= cfg_data;
          cpvl_pkg::REG_DRIVE_LOWER_BOUND:  lower_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_r <= in_measured_position;
          vel_r <= in_measured_velocity;
          tgt_r <= in_target_position;
        end
      end
      S_PERR: err_r <= add_y;
      S_MULP: begin
        prod_r <= 64'(mul_a) * 64'(mul_b);
        neg_r  <= err_r[31];
      end
      S_MULI: begin
        pterm_r <= fin_y;
        prod_r  <= 64'(mul_a) * 64'(mul_b);
      end
      S_INTEG: iclamp_r <= (integ_sum > lim_pos_w) || (integ_sum < lim_neg_w);
      S_SETP:  setp_r <= add_y;
      S_VERR:  err_r <= add_y;
      S_MULV: begin
        prod_r <= 64'(mul_a) * 64'(mul_b);
        neg_r  <= err_r[31];
      end
      S_DRIVE: begin
        if (out_free) begin
          out_vsp_r    <= setp_r;
          out_drive_r  <= drive_y;
          out_dclamp_r <= drive_hit;
          out_iclamp_r <= iclamp_r;
        end
      end
      default: ;
    endcase
  end

  // a result never overwrites one that is still waiting
  `CPVL_ASSERT_NEXT(a_hold_last_step, clk, rst_n,
    (state_r == S_DRIVE && out_valid_r && !out_ready), (state_r == S_DRIVE))
  // an accepted item keeps the block busy on the following cycle
  `CPVL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready), (!in_ready))
  // with ordered bounds a clamped drive sits on one of them
  `CPVL_ASSERT_NOW(a_clamp_on_bound, clk, rst_n,
    (out_valid_r && out_dclamp_r && (upper_r >= lower_r)),
    ((out_drive_r == upper_r) || (out_drive_r == lower_r)))

endmodule
`default_nettype wire
